// ----- sv/qcn_pkg.sv -----
// Shared constants, codes and stage payload types for the quadtree cell neighbour core.
package qcn_pkg;

    localparam int unsigned ID_W            = 32;
    localparam int unsigned MODE_W          = 3;
    localparam int unsigned DEPTH_W         = 4;
    localparam int unsigned DEPTH_LSB       = 28;
    localparam int unsigned LEVELS          = 14;
    localparam int unsigned CHILD_COUNT     = 4;
    localparam int unsigned BEAT_W          = 2;
    localparam int unsigned DEPTH_LIMIT_DEF = 14;

    typedef enum logic [MODE_W-1:0] {
        MODE_LEFT     = 3'd0,
        MODE_RIGHT    = 3'd1,
        MODE_TOP      = 3'd2,
        MODE_BOTTOM   = 3'd3,
        MODE_PARENT   = 3'd4,
        MODE_CHILDREN = 3'd5
    } t_mode;

    typedef enum logic [1:0] {
        OP_FAIL   = 2'd0,
        OP_NEIGH  = 2'd1,
        OP_PARENT = 2'd2,
        OP_CHILD  = 2'd3
    } t_op;

    // After decode: operation, axis select and the qualifying levels of that axis
    typedef struct packed {
        t_op               op;
        logic              row;
        logic [LEVELS-1:0] qual;
        logic [ID_W-1:0]   id;
    } t_dec;

    // After the scan: operation and the bits to flip for a neighbour move
    typedef struct packed {
        t_op             op;
        logic [ID_W-1:0] flip;
        logic [ID_W-1:0] id;
    } t_scan;

    // Finished result; a child result stands for a burst of four
    typedef struct packed {
        logic            ok;
        logic            child;
        logic [ID_W-1:0] id;
    } t_res;

endpackage

// ----- sv/qcn_if.sv -----
// Input and output channel interfaces of the quadtree cell neighbour core.
interface qcn_in_if
    import qcn_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [ID_W-1:0]   cell_id;

    modport source (output valid, output mode, output cell_id, input ready);
    modport sink   (input valid, input mode, input cell_id, output ready);
endinterface

interface qcn_out_if
    import qcn_pkg::*;
();
    logic            valid;
    logic            ready;
    logic            ok;
    logic [ID_W-1:0] cell_id_out;
    logic            last;

    modport source (output valid, output ok, output cell_id_out, output last, input ready);
    modport sink   (input valid, input ok, input cell_id_out, input last, output ready);
endinterface

// ----- sv/qcn_decode.sv -----
// Stage 1: mode and depth decode, qualifying-level vector of the chosen axis.
module qcn_decode
    import qcn_pkg::*;
#(
    parameter int unsigned DEPTH_LIMIT = DEPTH_LIMIT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [MODE_W-1:0] i_mode,
    input  logic [ID_W-1:0]   i_cell_id,
    output logic              o_valid,
    input  logic              i_ready,
    output t_dec              o_data
);

    localparam logic [DEPTH_W-1:0] LIMIT = DEPTH_W'(DEPTH_LIMIT);

    logic               r_valid;
    t_dec               r_data;
    t_dec               n_data;
    logic [DEPTH_W-1:0] depth;
    logic               up;
    logic [LEVELS-1:0]  lvl_mask;
    logic [LEVELS-1:0]  axis;

    assign depth = i_cell_id[ID_W-1:DEPTH_LSB];

    always_comb begin
        n_data.row = (i_mode == MODE_TOP) || (i_mode == MODE_BOTTOM);
        up         = (i_mode == MODE_RIGHT) || (i_mode == MODE_BOTTOM);
        for (int i = 0; i < LEVELS; i++) begin
            lvl_mask[i] = DEPTH_W'(i) < depth;
            axis[i]     = n_data.row ? i_cell_id[2*i+1] : i_cell_id[2*i];
        end
        // a level qualifies when it lies below the depth and its axis bit differs from the direction
        n_data.qual = (axis ^ {LEVELS{up}}) & lvl_mask;
        n_data.id   = i_cell_id;
        if (depth > LIMIT) begin
            n_data.op = OP_FAIL;
        end else begin
            unique case (i_mode)
                MODE_LEFT, MODE_RIGHT, MODE_TOP, MODE_BOTTOM: n_data.op = OP_NEIGH;
                MODE_PARENT:   n_data.op = (depth != '0) ? OP_PARENT : OP_FAIL;
                MODE_CHILDREN: n_data.op = (depth < LIMIT) ? OP_CHILD : OP_FAIL;
                default:       n_data.op = OP_FAIL;
            endcase
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ----- sv/qcn_scan.sv -----
// Stage 2: find the lowest qualifying level and build the flip mask.
module qcn_scan
    import qcn_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_dec  i_data,
    output logic  o_valid,
    input  logic  i_ready,
    output t_scan o_data
);

    logic              r_valid;
    t_scan             r_data;
    t_scan             n_data;
    logic [LEVELS-1:0] span;
    logic              found;

    always_comb begin
        found = |i_data.qual;
        // lowest qualifying level and every level below it
        span  = i_data.qual ^ (i_data.qual - LEVELS'(1));
        n_data.flip = '0;
        for (int i = 0; i < LEVELS; i++) begin
            n_data.flip[2*i]   = span[i] & !i_data.row;
            n_data.flip[2*i+1] = span[i] & i_data.row;
        end
        n_data.id = i_data.id;
        n_data.op = (i_data.op == OP_NEIGH && !found) ? OP_FAIL : i_data.op;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ----- sv/qcn_form.sv -----
// Stage 3: form the neighbour, parent or child base ID.
module qcn_form
    import qcn_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_scan i_data,
    output logic  o_valid,
    input  logic  i_ready,
    output t_res  o_data
);

    logic               r_valid;
    t_res               r_data;
    t_res               n_data;
    logic [DEPTH_W-1:0] depth;

    assign depth = i_data.id[ID_W-1:DEPTH_LSB];

    always_comb begin
        n_data.child = 1'b0;
        unique case (i_data.op)
            OP_NEIGH: begin
                n_data.ok = 1'b1;
                n_data.id = i_data.id ^ i_data.flip;
            end
            OP_PARENT: begin
                n_data.ok = 1'b1;
                n_data.id = {depth - DEPTH_W'(1), 2'b00, i_data.id[DEPTH_LSB-1:2]};
            end
            OP_CHILD: begin
                // top two path bits shift into the depth field and merge with it
                n_data.ok    = 1'b1;
                n_data.child = 1'b1;
                n_data.id    = {(depth + DEPTH_W'(1)) |
                                {2'b00, i_data.id[DEPTH_LSB-1:DEPTH_LSB-2]},
                                i_data.id[DEPTH_LSB-3:0], 2'b00};
            end
            default: begin
                n_data.ok = 1'b0;
                n_data.id = '0;
            end
        endcase
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ----- sv/qcn_burst.sv -----
// Output register: one transfer per result, four transfers for a child burst.
module qcn_burst
    import qcn_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  t_res            i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output logic            o_ok,
    output logic [ID_W-1:0] o_cell_id,
    output logic            o_last
);

    logic              r_valid;
    t_res              r_data;
    logic [BEAT_W-1:0] r_beat;
    logic              last;

    assign last    = !r_data.child || (r_beat == BEAT_W'(CHILD_COUNT - 1));
    assign o_ready = !r_valid || (i_ready && last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_beat  <= '0;
        end else if (o_ready) begin
            r_valid <= i_valid;
            r_beat  <= '0;
        end else if (i_ready) begin
            // advance within the child burst
            r_beat <= r_beat + BEAT_W'(1);
        end
        if (o_ready && i_valid) begin
            r_data <= i_data;
        end
    end

    assign o_valid   = r_valid;
    assign o_ok      = r_data.ok;
    assign o_cell_id = r_data.id | {{(ID_W-BEAT_W){1'b0}}, r_beat};
    assign o_last    = last;

endmodule

// ----- sv/quadtree_cell_id_neighbors_core.sv -----
// Top level of the quadtree cell neighbour, parent and child finder.
//
//   channel  | direction | payload                      | handshake
//   i_in     | in        | mode, cell_id                | valid / ready
//   o_out    | out       | ok, cell_id_out, last        | valid / ready
//
// Four register stages: decode, axis scan, ID formation, output register.
// Items pass the decode, scan, formation and output registers in turn; one item per
// cycle while the output accepts and no child burst holds the output register.
// A children request holds the output register for four transfers, so that
// item costs four transfers of output bandwidth.
// Synchronous active-low reset clears only the stage valid bits and burst counter.
// Each stage holds its data while downstream stalls; nothing is dropped or repeated.
module quadtree_cell_id_neighbors_core
    import qcn_pkg::*;
#(
    parameter int unsigned DEPTH_LIMIT = DEPTH_LIMIT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    qcn_in_if.sink    i_in,
    qcn_out_if.source o_out
);

    logic  dec_valid;
    logic  dec_ready;
    t_dec  dec_data;
    logic  scan_valid;
    logic  scan_ready;
    t_scan scan_data;
    logic  form_valid;
    logic  form_ready;
    t_res  form_data;

    qcn_decode #(
        .DEPTH_LIMIT(DEPTH_LIMIT)
    ) u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in.valid),
        .o_ready  (i_in.ready),
        .i_mode   (i_in.mode),
        .i_cell_id(i_in.cell_id),
        .o_valid  (dec_valid),
        .i_ready  (dec_ready),
        .o_data   (dec_data)
    );

    qcn_scan u_scan (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(dec_valid),
        .o_ready(dec_ready),
        .i_data (dec_data),
        .o_valid(scan_valid),
        .i_ready(scan_ready),
        .o_data (scan_data)
    );

    qcn_form u_form (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(scan_valid),
        .o_ready(scan_ready),
        .i_data (scan_data),
        .o_valid(form_valid),
        .i_ready(form_ready),
        .o_data (form_data)
    );

    qcn_burst u_burst (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (form_valid),
        .o_ready  (form_ready),
        .i_data   (form_data),
        .o_valid  (o_out.valid),
        .i_ready  (o_out.ready),
        .o_ok     (o_out.ok),
        .o_cell_id(o_out.cell_id_out),
        .o_last   (o_out.last)
    );

endmodule
